// ===== rtl/palette_fade_engine_top_macros.svh =====
// Assertion macros for the palette fade engine top level.
// Depends on a clock named clk and a synchronous reset named rst in the using scope.
`ifndef PALETTE_FADE_ENGINE_TOP_MACROS_SVH
`define PALETTE_FADE_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PFE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pfe_pkg.sv =====
// Shared types, constants and the per-entry fade step for the palette fade engine.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package pfe_pkg;

  // Default number of entries per palette bank.
  localparam int PALETTE_ENTRIES_DEF = 64;

  // Fixed field widths.
  localparam int COLOR_W    = 24;
  localparam int CFG_DATA_W = 6;

  // Fade arithmetic constants.
  localparam logic [7:0] STEP_SIZE   = 8'd32;
  localparam logic [7:0] FLASH_LEVEL = 8'd224;
  localparam logic [4:0] LAST_TICK   = 5'd21;
  localparam logic [5:0] LAST_INDEX  = 6'd63;

  // Operation codes.
  typedef enum logic [2:0] {
    OP_WR_CUR = 3'd0,
    OP_WR_TGT = 3'd1,
    OP_START  = 3'd2,
    OP_TICK   = 3'd3,
    OP_RD_CUR = 3'd4
  } op_t;

  // Fade modes.
  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_FADE_IN   = 3'd1,
    MODE_FADE_OUT  = 3'd2,
    MODE_FLASH_IN  = 3'd3,
    MODE_FLASH_OUT = 3'd4
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_FIRST_ENTRY = 2'd0,
    CFG_ENTRY_SPAN  = 2'd1,
    CFG_SKIP_BANK   = 2'd2
  } cfg_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_INIT,
    ST_SWEEP,
    ST_DRAIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clear_wr;
    logic host_wr;
    logic rd_issue;
    logic sweep_load;
    logic init_wr;
    logic sweep_rd;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       init_needed;
    logic       tick_run;
    logic       sweep_last;
    logic       clear_last;
  } ctrl_status_t;

  // One fade tick on one entry; colors are packed {red, green, blue}.
  function automatic logic [COLOR_W-1:0] fade_step(input mode_t m,
                                                   input logic [COLOR_W-1:0] cur,
                                                   input logic [COLOR_W-1:0] tgt);
    logic [7:0] cr, cg, cb, tr, tg, tb;
    logic [COLOR_W-1:0] res;
    cr = cur[23:16];
    cg = cur[15:8];
    cb = cur[7:0];
    tr = tgt[23:16];
    tg = tgt[15:8];
    tb = tgt[7:0];
    res = cur;
    case (m)
      MODE_FADE_IN: begin
        if (tb > cb) res[7:0] = cb + STEP_SIZE;
        else if (tg > cg) res[15:8] = cg + STEP_SIZE;
        else if (tr > cr) res[23:16] = cr + STEP_SIZE;
      end
      MODE_FADE_OUT: begin
        if (cr != 8'd0) res[23:16] = cr - STEP_SIZE;
        else if (cg != 8'd0) res[15:8] = cg - STEP_SIZE;
        else if (cb != 8'd0) res[7:0] = cb - STEP_SIZE;
      end
      MODE_FLASH_IN: begin
        if (tb < cb) res[7:0] = cb - STEP_SIZE;
        else if (tg < cg) res[15:8] = cg - STEP_SIZE;
        else if (tr < cr) res[23:16] = cr - STEP_SIZE;
      end
      default: begin
        if (cr != FLASH_LEVEL) res[23:16] = cr + STEP_SIZE;
        else if (cg != FLASH_LEVEL) res[15:8] = cg + STEP_SIZE;
        else if (cb != FLASH_LEVEL) res[7:0] = cb + STEP_SIZE;
      end
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/palette_fade_engine_top.sv =====
// Top level of the palette fade engine: controller, datapath and checks.
// Depends on pfe_pkg, pfe_ctrl, pfe_datapath and palette_fade_engine_top_macros.svh.
`default_nettype none
`include "palette_fade_engine_top_macros.svh"

// A transaction is taken when start is high and busy is low. Every transaction
// returns exactly one result, shown for a single cycle with result_valid high;
// the receiver cannot stall it, so it must capture the result in that cycle.
// After reset the block clears both palette memories, one address per cycle,
// and stays busy meanwhile; configuration writes are taken at any time.
// Writes, unknown operations and ticks that sweep nothing (idle mode, or
// fade-in with an empty range) finish without a sweep, reads wait for the
// registered memory read, a mode start stays busy while it resets its entries,
// and any other tick while it sweeps its entries (up to 2 * PALETTE_ENTRIES)
// and writes back the last one. The sweep rate is one entry per cycle, set by
// the single write port of the working palette memory. The result appears in
// the same cycle as busy falls.
module palette_fade_engine_top
  import pfe_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [2:0]            operation,
  input  wire logic                  bank,
  input  wire logic [5:0]            entry_index,
  input  wire logic [7:0]            red_in,
  input  wire logic [7:0]            green_in,
  input  wire logic [7:0]            blue_in,
  input  wire logic [2:0]            mode,
  output logic                       result_valid,
  output logic [7:0]                 red_out,
  output logic [7:0]                 green_out,
  output logic [7:0]                 blue_out,
  output logic                       done_res,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Sequencer.
  pfe_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  // Memories and arithmetic.
  pfe_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .operation   (operation),
    .bank        (bank),
    .entry_index (entry_index),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .mode        (mode),
    .red_out     (red_out),
    .green_out   (green_out),
    .blue_out    (blue_out),
    .done_res    (done_res)
  );

  // Checks on sequencing and results.
  `PFE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `PFE_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid, "result strobe lasted more than one cycle")
  `PFE_ASSERT_NOW(a_strobe_idle, result_valid, !busy, "result shown while the block is still busy")
  `PFE_ASSERT_NOW(a_done_no_color, result_valid && done_res, (red_out == 8'd0) && (green_out == 8'd0) && (blue_out == 8'd0), "tick result carries color data")

endmodule

`default_nettype wire

// ===== rtl/pfe_ctrl.sv =====
// Controller state machine for the palette fade engine.
// Depends on pfe_pkg; drives the datapath through ctrl_cmd_t and reads ctrl_status_t.
`default_nettype none

module pfe_ctrl
  import pfe_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire ctrl_status_t status,
  output ctrl_cmd_t         cmd,
  output logic              busy,
  output logic              result_valid
);

  state_t state;
  state_t state_next;

  // State register and the one-cycle result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= cmd.finish;
    end
  end

  assign busy = (state != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (status.op)
          OP_WR_CUR, OP_WR_TGT: begin
            cmd.host_wr = 1'b1;
            cmd.finish  = 1'b1;
            state_next  = ST_IDLE;
          end
          OP_RD_CUR: begin
            cmd.rd_issue = 1'b1;
            state_next   = ST_READ;
          end
          OP_START: begin
            if (status.init_needed) begin
              cmd.sweep_load = 1'b1;
              state_next     = ST_INIT;
            end else begin
              cmd.finish = 1'b1;
              state_next = ST_IDLE;
            end
          end
          OP_TICK: begin
            if (status.tick_run) begin
              cmd.sweep_load = 1'b1;
              state_next     = ST_SWEEP;
            end else begin
              cmd.finish = 1'b1;
              state_next = ST_IDLE;
            end
          end
          default: begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_READ: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (status.sweep_last) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        cmd.sweep_rd = 1'b1;
        if (status.sweep_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/pfe_datapath.sv =====
// Datapath of the palette fade engine: palette memories, sweep counter, fade step, results.
// Depends on pfe_pkg; commanded by pfe_ctrl.
`default_nettype none

module pfe_datapath
  import pfe_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ctrl_cmd_t             cmd,
  output ctrl_status_t               status,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [2:0]            operation,
  input  wire logic                  bank,
  input  wire logic [5:0]            entry_index,
  input  wire logic [7:0]            red_in,
  input  wire logic [7:0]            green_in,
  input  wire logic [7:0]            blue_in,
  input  wire logic [2:0]            mode,
  output logic [7:0]                 red_out,
  output logic [7:0]                 green_out,
  output logic [7:0]                 blue_out,
  output logic                       done_res
);

  localparam int EW        = $clog2(PALETTE_ENTRIES);
  localparam int AW        = EW + 1;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int RW        = (EW + 1 > 7) ? EW + 1 : 7;

  // Configuration registers.
  logic [5:0] first_entry;
  logic [5:0] entry_span;
  logic       skip_second_bank;

  // Latched transaction.
  logic [2:0]  op_q;
  logic        bank_q;
  logic [5:0]  idx_q;
  logic [23:0] color_q;
  mode_t       mode_q;

  // Fade state.
  mode_t      fade_mode;
  logic [4:0] tick_count;
  logic [4:0] tick_inc;
  logic       mode_active;

  // Memories and their ports.
  logic [COLOR_W-1:0] cur_mem [MEM_DEPTH];
  logic [COLOR_W-1:0] tgt_mem [MEM_DEPTH];
  logic [COLOR_W-1:0] cur_rd;
  logic [COLOR_W-1:0] tgt_rd;
  logic [AW-1:0]      rd_addr;
  logic               cur_we;
  logic [AW-1:0]      cur_waddr;
  logic [COLOR_W-1:0] cur_wdata;
  logic               tgt_we;
  logic [AW-1:0]      tgt_waddr;
  logic [COLOR_W-1:0] tgt_wdata;
  logic [AW-1:0]      host_addr;
  logic               idx_ok;

  // Clearing pass and sweep.
  logic [AW-1:0] clr_addr;
  logic [EW-1:0] sweep_entry;
  logic          sweep_bank;
  logic          wb_valid;
  logic [AW-1:0] wb_addr;

  // Fade-in range and sweep bounds.
  logic [RW-1:0] first_w;
  logic [RW-1:0] sum_w;
  logic [RW-1:0] last_w;
  logic          range_ok;
  logic [EW-1:0] range_lo;
  logic [EW-1:0] range_hi;
  logic          is_start;
  mode_t         sel_mode;
  logic          use_range;
  logic [EW-1:0] lo_s;
  logic [EW-1:0] hi_s;
  logic          bank_last;
  logic [COLOR_W-1:0] init_color;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_entry      <= 6'd0;
      entry_span       <= LAST_INDEX;
      skip_second_bank <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_ENTRY: first_entry      <= cfg_data[5:0];
        CFG_ENTRY_SPAN:  entry_span       <= cfg_data[5:0];
        CFG_SKIP_BANK:   skip_second_bank <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capture the transaction; unknown modes collapse to idle.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q    <= operation;
      bank_q  <= bank;
      idx_q   <= entry_index;
      color_q <= {red_in, green_in, blue_in};
      mode_q  <= (mode > MODE_FLASH_OUT) ? MODE_IDLE : mode_t'(mode);
    end
  end

  assign idx_ok    = RW'(idx_q) < RW'(PALETTE_ENTRIES);
  assign host_addr = {bank_q, EW'(idx_q)};

  // Fade-in range, end clipped at the last entry.
  assign first_w  = RW'(first_entry);
  assign sum_w    = first_w + RW'(entry_span);
  assign last_w   = RW'(PALETTE_ENTRIES - 1);
  assign range_ok = first_w <= last_w;
  assign range_lo = EW'(first_entry);
  assign range_hi = (sum_w > last_w) ? EW'(last_w) : EW'(sum_w);

  // Sweep bounds follow the starting mode on a start, else the active mode.
  assign is_start  = (op_q == OP_START);
  assign sel_mode  = is_start ? mode_q : fade_mode;
  assign use_range = (sel_mode == MODE_FADE_IN);
  assign lo_s      = use_range ? range_lo : '0;
  assign hi_s      = use_range ? range_hi : EW'(PALETTE_ENTRIES - 1);
  assign bank_last = is_start ? 1'b0 :
                     !(((fade_mode == MODE_FADE_IN) || (fade_mode == MODE_FLASH_IN))
                       && skip_second_bank);
  assign init_color = (mode_q == MODE_FADE_IN) ? '0 : {FLASH_LEVEL, FLASH_LEVEL, FLASH_LEVEL};

  assign mode_active = (fade_mode != MODE_IDLE);
  assign tick_inc    = tick_count + 5'd1;

  // Status toward the controller.
  always_comb begin
    status.op          = op_q;
    status.init_needed = ((mode_q == MODE_FADE_IN) && range_ok) || (mode_q == MODE_FLASH_IN);
    status.tick_run    = mode_active && ((fade_mode != MODE_FADE_IN) || range_ok);
    status.sweep_last  = (sweep_entry == hi_s) && (sweep_bank == bank_last);
    status.clear_last  = &clr_addr;
  end

  // Clearing pass address after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Sweep counter: entries lo to hi of bank 0, then of bank 1 when included.
  always_ff @(posedge clk) begin
    if (cmd.sweep_load) begin
      sweep_entry <= lo_s;
      sweep_bank  <= 1'b0;
    end else if (cmd.init_wr || cmd.sweep_rd) begin
      if (sweep_entry == hi_s) begin
        sweep_entry <= lo_s;
        sweep_bank  <= 1'b1;
      end else begin
        sweep_entry <= sweep_entry + EW'(1);
      end
    end
  end

  // Write-back stage of the tick sweep, one entry behind the read.
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= cmd.sweep_rd;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr <= {sweep_bank, sweep_entry};
  end

  // Read address: host read or sweep.
  assign rd_addr = cmd.sweep_rd ? {sweep_bank, sweep_entry} : host_addr;

  // Write port selection for the working palette.
  always_comb begin
    cur_we    = 1'b0;
    cur_waddr = host_addr;
    cur_wdata = color_q;
    if (cmd.clear_wr) begin
      cur_we    = 1'b1;
      cur_waddr = clr_addr;
      cur_wdata = '0;
    end else if (cmd.host_wr && (op_q == OP_WR_CUR) && idx_ok) begin
      cur_we = 1'b1;
    end else if (cmd.init_wr) begin
      cur_we    = 1'b1;
      cur_waddr = {1'b0, sweep_entry};
      cur_wdata = init_color;
    end else if (wb_valid) begin
      cur_we    = 1'b1;
      cur_waddr = wb_addr;
      cur_wdata = fade_step(fade_mode, cur_rd, tgt_rd);
    end
  end

  // Write port selection for the target palette.
  always_comb begin
    tgt_we    = 1'b0;
    tgt_waddr = host_addr;
    tgt_wdata = color_q;
    if (cmd.clear_wr) begin
      tgt_we    = 1'b1;
      tgt_waddr = clr_addr;
      tgt_wdata = '0;
    end else if (cmd.host_wr && (op_q == OP_WR_TGT) && idx_ok) begin
      tgt_we = 1'b1;
    end
  end

  // Palette memories with registered reads.
  always_ff @(posedge clk) begin
    if (cur_we) cur_mem[cur_waddr] <= cur_wdata;
    cur_rd <= cur_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (tgt_we) tgt_mem[tgt_waddr] <= tgt_wdata;
    tgt_rd <= tgt_mem[rd_addr];
  end

  // Mode and tick counter, updated when a start or a tick completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_mode  <= MODE_IDLE;
      tick_count <= 5'd0;
    end else if (cmd.finish) begin
      if (op_q == OP_START) begin
        fade_mode  <= mode_q;
        tick_count <= 5'd0;
      end else if ((op_q == OP_TICK) && mode_active) begin
        tick_count <= (tick_inc > LAST_TICK) ? 5'd0 : tick_inc;
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      red_out   <= 8'd0;
      green_out <= 8'd0;
      blue_out  <= 8'd0;
      done_res  <= 1'b0;
      if ((op_q == OP_RD_CUR) && idx_ok) begin
        red_out   <= cur_rd[23:16];
        green_out <= cur_rd[15:8];
        blue_out  <= cur_rd[7:0];
      end else if (op_q == OP_TICK) begin
        done_res <= !mode_active || (tick_inc > LAST_TICK);
      end
    end
  end

endmodule

`default_nettype wire
